/* rtl/bytecode_instruction_decoder_assert.svh */
// Assertion macros shared by the decoder RTL.
`ifndef BYTECODE_INSTRUCTION_DECODER_ASSERT_SVH
`define BYTECODE_INSTRUCTION_DECODER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define BID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a consequence holds in the cycle after its cause.
`define BID_ASSERT_NEXT(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cause) |=> (effect)) else $error(msg);

`endif

/* rtl/bid_pkg.sv */
package bid_pkg;

  // Header nibble limits and biases
  localparam logic [3:0] LenInlineMax = 4'd12;
  localparam logic [3:0] LenBias      = 4'd11;
  localparam logic [3:0] ValInlineMax = 4'd8;
  localparam logic [3:0] ValBias      = 4'd7;

  // Configuration register indexes
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgPayloadMask = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgSignedCode  = 8'd1;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       end_of_code;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         instr_type;
    logic signed [63:0] argument;
    logic [31:0]        instr_start;
    logic [31:0]        payload_offset;
    logic [31:0]        next_position;
    logic               truncated;
  } result_t;

  typedef struct packed {
    logic [15:0] payload_type_mask;
    logic [3:0]  signed_type_code;
  } cfg_t;

endpackage

/* rtl/bid_if.sv */
// Code byte channel
interface bid_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       end_of_code;

  modport source (output valid, output code_byte, output end_of_code, input ready);
  modport sink (input valid, input code_byte, input end_of_code, output ready);
endinterface

// Decoded instruction channel
interface bid_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         instr_type;
  logic signed [63:0] argument;
  logic [31:0]        instr_start;
  logic [31:0]        payload_offset;
  logic [31:0]        next_position;
  logic               truncated;

  modport source (output valid, output instr_type, output argument, output instr_start,
                  output payload_offset, output next_position, output truncated,
                  input ready);
  modport sink (input valid, input instr_type, input argument, input instr_start,
                input payload_offset, input next_position, input truncated,
                output ready);
endinterface

// Register write channel
interface bid_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bid_pkg::CfgIdxW-1:0]   index;
  logic [bid_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/bid_in_reg.sv */
module bid_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  bid_in_if.sink            in_i,
  input  logic              consume_i,
  output logic              valid_o,
  output bid_pkg::in_item_t item_o
);

  logic              valid_q, valid_d;
  bid_pkg::in_item_t item_q;
  logic              load;

  // Take a new request whenever the slot is empty or drains this cycle
  assign in_i.ready = !valid_q || consume_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold payload until replaced
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.code_byte   <= in_i.code_byte;
      item_q.end_of_code <= in_i.end_of_code;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* rtl/bid_decode.sv */
`include "bytecode_instruction_decoder_assert.svh"

module bid_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bid_pkg::cfg_t     cfg_i,
  input  bid_pkg::in_item_t item_i,
  input  logic              fire_i,
  output logic              res_valid_o,
  output bid_pkg::result_t  res_o
);

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhNumber  = 2'd1,
    PhPayload = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  type_q, type_d;
  logic [3:0]  left_q, left_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] pay_left_q, pay_left_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] start_q, start_d;

  // Decode one byte against the current state
  always_comb begin
    logic [7:0]  b;
    logic [3:0]  n;
    logic [31:0] nxt;
    logic [2:0]  idx;
    logic [63:0] acc_new;
    logic [63:0] v;
    logic [5:0]  sbit;
    logic        sgn;
    logic        done;
    logic [63:0] arg;
    logic [31:0] poff;

    b       = item_i.code_byte;
    n       = b[7:4];
    nxt     = pos_q + 32'd1;
    idx     = 3'(cnt_q - left_q);
    acc_new = acc_q;
    v       = 64'd0;
    sbit    = 6'({cnt_q[2:0], 3'b000} - 6'd1);
    sgn     = 1'b0;
    done    = 1'b0;
    arg     = 64'd0;
    poff    = 32'd0;

    phase_d    = phase_q;
    type_d     = type_q;
    left_d     = left_q;
    cnt_d      = cnt_q;
    acc_d      = acc_q;
    pay_left_d = pay_left_q;
    start_d    = start_q;

    unique case (phase_q)
      PhNumber: begin
        // Merge the byte into its little-endian lane
        for (int k = 0; k < 8; k++) begin
          if (idx == 3'(k)) begin
            acc_new[8*k +: 8] = acc_q[8*k +: 8] | b;
          end
        end
        acc_d  = acc_new;
        left_d = left_q - 4'd1;
        if (left_d == 4'd0) begin
          if (cfg_i.payload_type_mask[type_q]) begin
            pay_left_d = acc_new[31:0];
            acc_d      = {32'd0, acc_new[31:0]};
            if (acc_new[31:0] == 32'd0) begin
              done = 1'b1;
              poff = nxt;
            end else begin
              phase_d = PhPayload;
            end
          end else begin
            // Sign-extend a short value of the signed type
            v   = acc_new;
            sgn = acc_new[sbit];
            if (type_q == cfg_i.signed_type_code && cnt_q >= 4'd1 && cnt_q < 4'd8) begin
              for (int k = 0; k < 8; k++) begin
                if (4'(k) >= cnt_q) begin
                  v[8*k +: 8] = {8{sgn}};
                end
              end
            end
            done = 1'b1;
            arg  = v;
          end
        end
      end
      PhPayload: begin
        // Skip payload bytes
        pay_left_d = pay_left_q - 32'd1;
        if (pay_left_d == 32'd0) begin
          done = 1'b1;
          arg  = acc_q;
          poff = start_q + 32'd1 + {28'd0, cnt_q};
        end
      end
      default: begin
        // Header byte: type in low nibble, size or value in high nibble
        type_d  = b[3:0];
        start_d = pos_q;
        acc_d   = 64'd0;
        cnt_d   = 4'd0;
        left_d  = 4'd0;
        phase_d = PhHeader;
        if (cfg_i.payload_type_mask[b[3:0]]) begin
          if (n >= bid_pkg::LenInlineMax) begin
            cnt_d   = n - bid_pkg::LenBias;
            left_d  = n - bid_pkg::LenBias;
            phase_d = PhNumber;
          end else if (n == 4'd0) begin
            done = 1'b1;
            poff = nxt;
          end else begin
            acc_d      = {60'd0, n};
            pay_left_d = {28'd0, n};
            phase_d    = PhPayload;
          end
        end else begin
          if (n >= bid_pkg::ValInlineMax) begin
            cnt_d   = n - bid_pkg::ValBias;
            left_d  = n - bid_pkg::ValBias;
            phase_d = PhNumber;
          end else begin
            done = 1'b1;
            arg  = {60'd0, n};
          end
        end
      end
    endcase

    // Build the result
    res_o.instr_type     = type_d;
    res_o.instr_start    = start_d;
    res_o.next_position  = nxt;
    res_o.argument       = done ? arg : 64'd0;
    res_o.payload_offset = done ? poff : 32'd0;
    res_o.truncated      = !done;
    res_valid_o          = done || item_i.end_of_code;

    if (done) begin
      phase_d = PhHeader;
    end

    // Restart positions at end of code
    if (item_i.end_of_code) begin
      phase_d    = PhHeader;
      left_d     = 4'd0;
      pay_left_d = 32'd0;
      pos_d      = 32'd0;
    end else begin
      pos_d = nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHeader;
      type_q     <= 4'd0;
      left_q     <= 4'd0;
      cnt_q      <= 4'd0;
      acc_q      <= 64'd0;
      pay_left_q <= 32'd0;
      pos_q      <= 32'd0;
      start_q    <= 32'd0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      type_q     <= type_d;
      left_q     <= left_d;
      cnt_q      <= cnt_d;
      acc_q      <= acc_d;
      pay_left_q <= pay_left_d;
      pos_q      <= pos_d;
      start_q    <= start_d;
    end
  end

  `BID_ASSERT(a_number_has_bytes, (phase_q != PhNumber) || (left_q != 4'd0), "number phase with no bytes left")
  `BID_ASSERT(a_payload_has_bytes, (phase_q != PhPayload) || (pay_left_q != 32'd0), "payload phase with no bytes left")
  `BID_ASSERT_NEXT(a_end_restarts, fire_i && item_i.end_of_code, (pos_q == 32'd0) && (phase_q == PhHeader), "end of code did not restart decoding")

endmodule

/* rtl/bid_out_reg.sv */
module bid_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  bid_pkg::result_t res_i,
  output logic             free_o,
  bid_out_if.source        out_o
);

  logic             valid_q, valid_d;
  bid_pkg::result_t res_q;

  // Slot can take a result when empty or being drained
  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.instr_type     = res_q.instr_type;
  assign out_o.argument       = res_q.argument;
  assign out_o.instr_start    = res_q.instr_start;
  assign out_o.payload_offset = res_q.payload_offset;
  assign out_o.next_position  = res_q.next_position;
  assign out_o.truncated      = res_q.truncated;

endmodule

/* rtl/bytecode_instruction_decoder.sv */
// Channel   Dir  Handshake     Carries
// in_i      in   valid/ready   code_byte, end_of_code
// out_o     out  valid/ready   instr_type, argument, instr_start, payload_offset,
//                              next_position, truncated
// cfg_i     in   valid/ready   index, data (register write, always ready)
//
// One code byte per cycle sustained while the result register is not stalled.
// A byte is held in the input register, decoded combinationally, and its result is captured in the result register.
// Reset clears decoder state, configuration registers and valid flags; positions start at 0.
// A stalled result holds the input register, and input ready drops once both are full.
module bytecode_instruction_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  bid_in_if.sink    in_i,
  bid_out_if.source out_o,
  bid_cfg_if.sink   cfg_i
);

  bid_pkg::cfg_t     cfg_q;
  bid_pkg::in_item_t item;
  bid_pkg::result_t  res;
  logic              item_valid;
  logic              res_valid;
  logic              out_free;
  logic              fire;

  // Register writes are always accepted
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        bid_pkg::CfgPayloadMask: cfg_q.payload_type_mask <= cfg_i.data;
        bid_pkg::CfgSignedCode:  cfg_q.signed_type_code  <= cfg_i.data[3:0];
        default: ;
      endcase
    end
  end

  // Advance the held byte unless its result has nowhere to go
  assign fire = item_valid && (out_free || !res_valid);

  bid_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .consume_i (fire),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  bid_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (item),
    .fire_i      (fire),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bid_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (fire && res_valid),
    .res_i  (res),
    .free_o (out_free),
    .out_o  (out_o)
  );

endmodule
